FILE: src/rmh_pkg.sv
`timescale 1ns / 1ps
package rmh_pkg;

    typedef enum logic [3:0] {
        S_IDLE, S_INS, S_UP_CHK, S_UP_CMP, S_BAL, S_TAKE, S_DN_CHK, S_DN_CMP,
        S_XFER, S_MED_RD, S_MED_CALC, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE, RD_PARENT, RD_CHILDREN, RD_TOP_LAST, RD_TOPS
    } t_rd;

    typedef struct packed {
        logic start;
        logic ins_begin;
        t_rd  rd;
        logic place;
        logic up_step;
        logic bal_begin;
        logic take;
        logic dn_step;
        logic xfer;
        logic med;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic pos_zero;
        logic up_go;
        logic need_bal;
        logic child_none;
        logic dn_go;
    } t_sts;

    // a belongs strictly nearer the top than b
    function automatic logic ranks_over(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic is_max);
        ranks_over = is_max ? (a > b) : (a < b);
    endfunction

endpackage

FILE: src/running_median_two_heaps_unit.sv
// A dropped sample goes straight to the result; the time a stored one takes is
// set by the sift walks over the heap memories.
// One sample is handled at a time; the next is taken once the result is
// queued, later while an earlier result is still stalled.
// Reset (synchronous, active low) empties both heaps and zeroes the median.
`timescale 1ns / 1ps
module running_median_two_heaps_unit
    import rmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [32:0] o_median_doubled,
    output logic [10:0]        o_count,
    output logic               o_dropped
);

    t_cmd w_cmd;
    t_sts w_sts;

    rmh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    rmh_dpath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample         (i_sample),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_median_doubled (o_median_doubled),
        .o_count          (o_count),
        .o_dropped        (o_dropped)
    );

`ifndef SYNTH
    a_balanced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |-> !w_sts.need_bal)
        else $error("heap sizes out of balance at transaction start");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> o_count == 11'(2 * HEAP_DEPTH - 1))
        else $error("sample dropped while store not full");

    a_count_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_dropped |-> o_count != 11'd0)
        else $error("stored sample reported with zero count");
`endif

endmodule

FILE: src/rmh_ctrl.sv
`timescale 1ns / 1ps
module rmh_ctrl
    import rmh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  logic i_out_stall,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        case (r_state)
            S_IDLE: begin
                n_second = 1'b0;
                if (i_in_valid) n_state = i_sts.full ? S_DONE : S_INS;
            end
            S_INS: n_state = S_UP_CHK;
            S_UP_CHK: begin
                if (i_sts.pos_zero) n_state = r_second ? S_MED_RD : S_BAL;
                else                n_state = S_UP_CMP;
            end
            S_UP_CMP: begin
                if (i_sts.up_go) n_state = S_UP_CHK;
                else             n_state = r_second ? S_MED_RD : S_BAL;
            end
            S_BAL:    n_state = i_sts.need_bal ? S_TAKE : S_MED_RD;
            S_TAKE:   n_state = S_DN_CHK;
            S_DN_CHK: n_state = i_sts.child_none ? S_XFER : S_DN_CMP;
            S_DN_CMP: n_state = i_sts.dn_go ? S_DN_CHK : S_XFER;
            S_XFER: begin
                n_second = 1'b1;
                n_state  = S_INS;
            end
            S_MED_RD:   n_state = S_MED_CALC;
            S_MED_CALC: n_state = S_DONE;
            S_DONE:     if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd       = '0;
        o_cmd.rd    = RD_NONE;
        o_in_stall  = (r_state != S_IDLE);
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE:   o_cmd.start = i_in_valid;
            S_INS:    o_cmd.ins_begin = 1'b1;
            S_UP_CHK: begin
                if (i_sts.pos_zero) o_cmd.place = 1'b1;
                else                o_cmd.rd = RD_PARENT;
            end
            S_UP_CMP: begin
                if (i_sts.up_go) o_cmd.up_step = 1'b1;
                else             o_cmd.place = 1'b1;
            end
            S_BAL: begin
                if (i_sts.need_bal) begin
                    o_cmd.bal_begin = 1'b1;
                    o_cmd.rd        = RD_TOP_LAST;
                end
            end
            S_TAKE:   o_cmd.take = 1'b1;
            S_DN_CHK: begin
                if (i_sts.child_none) o_cmd.place = 1'b1;
                else                  o_cmd.rd = RD_CHILDREN;
            end
            S_DN_CMP: begin
                if (i_sts.dn_go) o_cmd.dn_step = 1'b1;
                else             o_cmd.place = 1'b1;
            end
            S_XFER:     o_cmd.xfer = 1'b1;
            S_MED_RD:   o_cmd.rd = RD_TOPS;
            S_MED_CALC: o_cmd.med = 1'b1;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: src/rmh_dpath.sv
`timescale 1ns / 1ps
module rmh_dpath
    import rmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_sample,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic signed [32:0] o_median_doubled,
    output logic [10:0]        o_count,
    output logic               o_dropped
);

    localparam int AW = (HEAP_DEPTH > 2) ? $clog2(HEAP_DEPTH) : 1;
    localparam int SW = $clog2(HEAP_DEPTH + 1);
    localparam int TW = SW + 1;
    localparam int CW = AW + 2;
    localparam logic [TW-1:0] CAPACITY = TW'(2 * HEAP_DEPTH - 1);

    logic signed [31:0] r_lmem [HEAP_DEPTH];
    logic signed [31:0] r_umem [HEAP_DEPTH];
    logic signed [31:0] r_lrd0, r_lrd1, r_urd0, r_urd1;

    logic [SW-1:0]      r_lsize, r_usize;
    logic               r_sel;          // 1: lower max-heap
    logic signed [31:0] r_val, r_top;
    logic [AW-1:0]      r_pos;
    logic [SW-1:0]      r_n;
    logic signed [33:0] r_med;
    logic               r_dropped;
    logic signed [32:0] r_out_med;
    logic [10:0]        r_out_count;
    logic               r_out_drop;

    logic [AW-1:0]      w_ra0, w_ra1;
    logic               w_we;
    logic [AW-1:0]      w_wa;
    logic signed [31:0] w_wd;
    logic [SW-1:0]      w_size_sel, w_big_size;
    logic               w_big;
    logic signed [31:0] w_rd0, w_rd1, w_cval;
    logic [CW-1:0]      w_child, w_child_r;
    logic               w_pick_r;
    logic [TW-1:0]      w_total;
    logic signed [33:0] w_s2;

    assign w_size_sel = r_sel ? r_lsize : r_usize;
    assign w_big      = (r_lsize > r_usize);
    assign w_big_size = w_big ? r_lsize : r_usize;
    assign w_rd0      = r_sel ? r_lrd0 : r_urd0;
    assign w_rd1      = r_sel ? r_lrd1 : r_urd1;
    assign w_child    = {1'b0, r_pos, 1'b1};
    assign w_child_r  = w_child + CW'(1);
    assign w_total    = TW'(r_lsize) + TW'(r_usize);
    assign w_s2       = {{1{i_sample[31]}}, i_sample, 1'b0};

    assign w_pick_r = (w_child_r < CW'(r_n)) && ranks_over(w_rd1, w_rd0, r_sel);
    assign w_cval   = w_pick_r ? w_rd1 : w_rd0;

    always_comb begin
        w_ra0 = '0;
        w_ra1 = '0;
        case (i_cmd.rd)
            RD_PARENT:   w_ra0 = AW'((r_pos - AW'(1)) >> 1);
            RD_CHILDREN: begin
                w_ra0 = w_child[AW-1:0];
                w_ra1 = w_child_r[AW-1:0];
            end
            RD_TOP_LAST: w_ra1 = AW'(w_big_size - SW'(1));
            default: ;
        endcase
    end

    always_comb begin
        w_we = i_cmd.place | i_cmd.up_step | i_cmd.dn_step;
        w_wa = r_pos;
        w_wd = r_val;
        if (i_cmd.up_step) w_wd = w_rd0;
        if (i_cmd.dn_step) w_wd = w_cval;
    end

    always_ff @(posedge i_clk) begin
        if (w_we && r_sel) r_lmem[w_wa] <= w_wd;
        if (w_we && !r_sel) r_umem[w_wa] <= w_wd;
        r_lrd0 <= r_lmem[w_ra0];
        r_lrd1 <= r_lmem[w_ra1];
        r_urd0 <= r_umem[w_ra0];
        r_urd1 <= r_umem[w_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsize <= '0;
            r_usize <= '0;
            r_med   <= '0;
        end else begin
            if (i_cmd.ins_begin) begin
                if (r_sel) r_lsize <= r_lsize + SW'(1);
                else       r_usize <= r_usize + SW'(1);
            end
            if (i_cmd.bal_begin) begin
                if (w_big) r_lsize <= r_lsize - SW'(1);
                else       r_usize <= r_usize - SW'(1);
            end
            if (i_cmd.med) begin
                if (w_total[0]) begin
                    r_med <= w_big ? {{1{r_lrd0[31]}}, r_lrd0, 1'b0}
                                   : {{1{r_urd0[31]}}, r_urd0, 1'b0};
                end else begin
                    r_med <= 34'(r_lrd0) + 34'(r_urd0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_val     <= i_sample;
            r_dropped <= o_sts.full;
            r_sel     <= (w_s2 <= r_med);
        end
        if (i_cmd.ins_begin) r_pos <= AW'(w_size_sel);
        if (i_cmd.up_step)   r_pos <= AW'((r_pos - AW'(1)) >> 1);
        if (i_cmd.bal_begin) r_sel <= w_big;
        if (i_cmd.take) begin
            r_top <= w_rd0;
            r_val <= w_rd1;
            r_pos <= '0;
            r_n   <= w_size_sel;
        end
        if (i_cmd.dn_step) r_pos <= w_pick_r ? w_child_r[AW-1:0] : w_child[AW-1:0];
        if (i_cmd.xfer) begin
            r_sel <= ~r_sel;
            r_val <= r_top;
        end
        if (i_cmd.publish) begin
            r_out_med   <= r_med[32:0];
            r_out_count <= 11'(w_total);
            r_out_drop  <= r_dropped;
        end
    end

    assign o_sts.full       = (w_total >= CAPACITY);
    assign o_sts.pos_zero   = (r_pos == '0);
    assign o_sts.up_go      = ranks_over(r_val, w_rd0, r_sel);
    assign o_sts.need_bal   = (TW'(r_lsize) > TW'(r_usize) + TW'(1)) ||
                              (TW'(r_usize) > TW'(r_lsize) + TW'(1));
    assign o_sts.child_none = (w_child >= CW'(r_n));
    assign o_sts.dn_go      = ranks_over(w_cval, r_val, r_sel);

    assign o_median_doubled = r_out_med;
    assign o_count          = r_out_count;
    assign o_dropped        = r_out_drop;

endmodule

FILE: bench/tb_running_median_two_heaps_unit.sv
`timescale 1ns / 1ps
module tb_running_median_two_heaps_unit;

    localparam int DEPTH     = 1024;
    localparam int CAPACITY  = 2 * DEPTH - 1;
    localparam int N_RANDOM  = 1920;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic signed [32:0] median_doubled;
        logic [10:0]        count;
        logic               dropped;
    } t_expect;

    // two-heap running median, tracked alongside the block
    class median_tracker;
        int        lower[DEPTH];
        int        upper[DEPTH];
        int        n_lower;
        int        n_upper;
        longint    med2;
        t_expect   pending_q[$];

        function new();
            n_lower = 0;
            n_upper = 0;
            med2    = 0;
        endfunction

        function bit better(int a, int b, bit is_max);
            return is_max ? (a > b) : (a < b);
        endfunction

        function void push(ref int h[DEPTH], ref int n, input int v, input bit is_max);
            int pos;
            int par;
            int t;
            pos = n;
            h[pos] = v;
            n++;
            while (pos > 0) begin
                par = (pos - 1) / 2;
                if (!better(h[pos], h[par], is_max)) break;
                t = h[pos]; h[pos] = h[par]; h[par] = t;
                pos = par;
            end
        endfunction

        function int pop(ref int h[DEPTH], ref int n, input bit is_max);
            int top;
            int pos;
            int ch;
            int t;
            top = h[0];
            n--;
            h[0] = h[n];
            pos = 0;
            forever begin
                ch = 2 * pos + 1;
                if (ch >= n) break;
                if (ch + 1 < n && better(h[ch + 1], h[ch], is_max)) ch++;
                if (!better(h[ch], h[pos], is_max)) break;
                t = h[pos]; h[pos] = h[ch]; h[ch] = t;
                pos = ch;
            end
            return top;
        endfunction

        function void note_sample(logic signed [31:0] s);
            t_expect e;
            int      v;
            e.dropped = 1'b0;
            if (n_lower + n_upper >= CAPACITY) begin
                e.dropped = 1'b1;
            end else begin
                if (2 * longint'(s) <= med2) push(lower, n_lower, s, 1'b1);
                else push(upper, n_upper, s, 1'b0);
                if (n_lower > n_upper + 1) begin
                    v = pop(lower, n_lower, 1'b1);
                    push(upper, n_upper, v, 1'b0);
                end else if (n_upper > n_lower + 1) begin
                    v = pop(upper, n_upper, 1'b0);
                    push(lower, n_lower, v, 1'b1);
                end
                if ((n_lower + n_upper) % 2 == 1)
                    med2 = 2 * longint'(n_lower > n_upper ? lower[0] : upper[0]);
                else
                    med2 = longint'(lower[0]) + longint'(upper[0]);
            end
            e.median_doubled = med2[32:0];
            e.count          = 11'(n_lower + n_upper);
            pending_q.push_back(e);
        endfunction

        // returns an empty string when the transaction matches
        function string check_result(logic signed [32:0] m, logic [10:0] c, logic d);
            t_expect e;
            if (pending_q.size() == 0)
                return $sformatf("result with nothing expected: med2=%0d count=%0d", m, c);
            e = pending_q.pop_front();
            if (m !== e.median_doubled || c !== e.count || d !== e.dropped)
                return $sformatf("got med2=%0d count=%0d dropped=%0b, want %0d %0d %0b",
                                 m, c, d, e.median_doubled, e.count, e.dropped);
            return "";
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic signed [31:0] i_sample = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic signed [32:0] o_median_doubled;
    logic [10:0]        o_count;
    logic               o_dropped;

    median_tracker tracker = new();
    int  n_errors = 0;
    int  idle_cycles = 0;
    bit  long_hold = 1'b0;

    running_median_two_heaps_unit #(.HEAP_DEPTH(DEPTH)) dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // input and output monitors, plus the idle watchdog
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) tracker.note_sample(i_sample);
            if (o_out_valid && !i_out_stall) begin
                msg = tracker.check_result(o_median_doubled, o_count, o_dropped);
                if (msg != "") report(msg);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("running_median_two_heaps_unit: mismatch");
                $finish;
            end
        end
    end

    // receiver stall pattern: modes change every so often
    always @(posedge i_clk) begin
        int mode_left;
        int mode;
        if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 400);
        end else begin
            mode_left--;
        end
        case (mode)
            0:       i_out_stall <= long_hold;
            1:       i_out_stall <= long_hold | ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= long_hold | ($urandom_range(0, 3) != 0);
            default: i_out_stall <= long_hold | ($urandom_range(0, 1) == 1);
        endcase
    end

    // long output hold-off while the sender keeps offering
    initial begin
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (800) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    task automatic send(logic signed [31:0] s);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            i_sample   <= $urandom;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 16) - 8;          // many equal values
            2:       return 32'sh7fffffff - $urandom_range(0, 3);
            3:       return 32'sh80000000 + $urandom_range(0, 3);
            4:       return tracker.med2[32:1] + $urandom_range(0, 4) - 2;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic signed [31:0] directed[$];
        int burst;
        directed = {0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                    32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, -1, 1,
                    5, 5, 5, 5, 5, -5, -5, 32'sh55555555, 32'shaaaaaaaa, 7, 6, 8};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send(directed[k]);
        idle(1);
        for (int k = 0; k < N_RANDOM; k += burst) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst; j++) send(pick_sample());
            if (k < 600 && k + burst >= 600) begin
                // drain completely before going on
                i_in_valid <= 1'b0;
                wait (tracker.pending_q.size() == 0);
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                idle($urandom_range(1, 40));
            end
        end
        i_in_valid <= 1'b0;
        wait (tracker.pending_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (tracker.pending_q.size() != 0) report("results still outstanding at end");
        if (n_errors == 0) begin
            $display("running_median_two_heaps_unit: match");
        end else begin
            $display("running_median_two_heaps_unit: mismatch");
        end
        $finish;
    end

endmodule
